### hdl/drgb_pkg.sv
// Package for the dual RGB LED PWM blinker.
// Holds the shared widths, register indexes, blink modes and structs; no dependencies.
`default_nettype none
package drgb_pkg;

    localparam int unsigned LEVEL_W   = 7;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned PHASE_W   = 7;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 7;
    localparam int unsigned CHAN_N    = 6;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    typedef enum logic [MODE_W-1:0] {
        BLINK_STEADY = 2'd0,
        BLINK_SLOW   = 2'd1,
        BLINK_FAST   = 2'd2
    } t_blink_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_RED    = 3'd0,
        REG_LEFT_GREEN  = 3'd1,
        REG_LEFT_BLUE   = 3'd2,
        REG_LEFT_MODE   = 3'd3,
        REG_RIGHT_RED   = 3'd4,
        REG_RIGHT_GREEN = 3'd5,
        REG_RIGHT_BLUE  = 3'd6,
        REG_RIGHT_MODE  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] left_red;
        logic [LEVEL_W-1:0] left_green;
        logic [LEVEL_W-1:0] left_blue;
        t_blink_mode        left_mode;
        logic [LEVEL_W-1:0] right_red;
        logic [LEVEL_W-1:0] right_green;
        logic [LEVEL_W-1:0] right_blue;
        t_blink_mode        right_mode;
    } t_cfg;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               slow_lit;
        logic               fast_lit;
    } t_tb_state;

endpackage
`default_nettype wire

### hdl/drgb_cfg_regs.sv
// Configuration registers of the dual RGB LED PWM blinker, with write saturation.
// Depends on drgb_pkg.
`default_nettype none
module drgb_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [drgb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [drgb_pkg::CFG_W-1:0]     i_cfg_data,
    output drgb_pkg::t_cfg                      o_cfg
);

    drgb_pkg::t_cfg                    r_cfg;
    drgb_pkg::t_cfg                    n_cfg;
    logic [drgb_pkg::LEVEL_W-1:0]      sat_level;
    drgb_pkg::t_blink_mode             sat_mode;

    always_comb begin
        sat_level = (i_cfg_data[drgb_pkg::LEVEL_W-1:0] > drgb_pkg::LEVEL_MAX) ?
                    drgb_pkg::LEVEL_MAX : i_cfg_data[drgb_pkg::LEVEL_W-1:0];
        case (i_cfg_data[drgb_pkg::MODE_W-1:0])
            drgb_pkg::BLINK_STEADY: sat_mode = drgb_pkg::BLINK_STEADY;
            drgb_pkg::BLINK_SLOW:   sat_mode = drgb_pkg::BLINK_SLOW;
            default:                sat_mode = drgb_pkg::BLINK_FAST;
        endcase
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (drgb_pkg::t_cfg_idx'(i_cfg_idx))
                drgb_pkg::REG_LEFT_RED:    n_cfg.left_red    = sat_level;
                drgb_pkg::REG_LEFT_GREEN:  n_cfg.left_green  = sat_level;
                drgb_pkg::REG_LEFT_BLUE:   n_cfg.left_blue   = sat_level;
                drgb_pkg::REG_LEFT_MODE:   n_cfg.left_mode   = sat_mode;
                drgb_pkg::REG_RIGHT_RED:   n_cfg.right_red   = sat_level;
                drgb_pkg::REG_RIGHT_GREEN: n_cfg.right_green = sat_level;
                drgb_pkg::REG_RIGHT_BLUE:  n_cfg.right_blue  = sat_level;
                drgb_pkg::REG_RIGHT_MODE:  n_cfg.right_mode  = sat_mode;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{left_mode: drgb_pkg::BLINK_STEADY, right_mode: drgb_pkg::BLINK_STEADY,
                       default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### hdl/drgb_timebase.sv
// Tick-driven time base: slow and fast blink counters and the PWM phase counter.
// Depends on drgb_pkg.
`default_nettype none
module drgb_timebase #(
    parameter int unsigned PWM_PERIOD      = 100,
    parameter int unsigned SLOW_HALF_TICKS = 500,
    parameter int unsigned FAST_HALF_TICKS = 100
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire logic      i_tick,
    output drgb_pkg::t_tb_state o_next
);

    localparam logic [drgb_pkg::HALF_W-1:0]  SlowLimit = drgb_pkg::HALF_W'(SLOW_HALF_TICKS);
    localparam logic [drgb_pkg::HALF_W-1:0]  FastLimit = drgb_pkg::HALF_W'(FAST_HALF_TICKS);
    localparam logic [drgb_pkg::PHASE_W:0]   PhaseLimit = (drgb_pkg::PHASE_W+1)'(PWM_PERIOD);

    logic [drgb_pkg::HALF_W-1:0]  r_slow_cnt, n_slow_cnt;
    logic [drgb_pkg::HALF_W-1:0]  r_fast_cnt, n_fast_cnt;
    logic [drgb_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic                         r_slow_lit, n_slow_lit;
    logic                         r_fast_lit, n_fast_lit;
    logic [drgb_pkg::HALF_W-1:0]  slow_inc;
    logic [drgb_pkg::HALF_W-1:0]  fast_inc;
    logic [drgb_pkg::PHASE_W:0]   phase_inc;

    always_comb begin
        slow_inc  = r_slow_cnt + drgb_pkg::HALF_W'(1);
        fast_inc  = r_fast_cnt + drgb_pkg::HALF_W'(1);
        phase_inc = {1'b0, r_phase} + (drgb_pkg::PHASE_W+1)'(1);

        n_slow_cnt = r_slow_cnt;
        n_fast_cnt = r_fast_cnt;
        n_phase    = r_phase;
        n_slow_lit = r_slow_lit;
        n_fast_lit = r_fast_lit;
        if (i_tick) begin
            if (slow_inc >= SlowLimit) begin
                n_slow_cnt = '0;
                n_slow_lit = ~r_slow_lit;
            end else begin
                n_slow_cnt = slow_inc;
            end
            if (fast_inc >= FastLimit) begin
                n_fast_cnt = '0;
                n_fast_lit = ~r_fast_lit;
            end else begin
                n_fast_cnt = fast_inc;
            end
            if (phase_inc >= PhaseLimit) begin
                n_phase = '0;
            end else begin
                n_phase = phase_inc[drgb_pkg::PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_cnt <= '0;
            r_fast_cnt <= '0;
            r_phase    <= '0;
            r_slow_lit <= 1'b1;
            r_fast_lit <= 1'b1;
        end else if (i_accept) begin
            r_slow_cnt <= n_slow_cnt;
            r_fast_cnt <= n_fast_cnt;
            r_phase    <= n_phase;
            r_slow_lit <= n_slow_lit;
            r_fast_lit <= n_fast_lit;
        end
    end

    assign o_next = '{phase: n_phase, slow_lit: n_slow_lit, fast_lit: n_fast_lit};

endmodule
`default_nettype wire

### hdl/drgb_result_stage.sv
// Channel compare and blink gating, followed by the output register and a skid word.
// Depends on drgb_pkg.
`default_nettype none
module drgb_result_stage (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire drgb_pkg::t_tb_state            i_next,
    input  wire drgb_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [drgb_pkg::CHAN_N-1:0]         o_out_chan,
    output logic                                o_room
);

    logic                         left_dark;
    logic                         right_dark;
    logic [drgb_pkg::CHAN_N-1:0]  chan;
    logic                         r_out_valid;
    logic [drgb_pkg::CHAN_N-1:0]  r_out_chan;
    logic                         r_skid_valid;
    logic [drgb_pkg::CHAN_N-1:0]  r_skid_chan;
    logic                         out_take;

    function automatic logic dark_of(input drgb_pkg::t_blink_mode mode,
                                     input drgb_pkg::t_tb_state st);
        logic d;
        case (mode)
            drgb_pkg::BLINK_SLOW: d = ~st.slow_lit;
            drgb_pkg::BLINK_FAST: d = ~st.fast_lit;
            default:              d = 1'b0;
        endcase
        return d;
    endfunction

    always_comb begin
        left_dark  = dark_of(i_cfg.left_mode, i_next);
        right_dark = dark_of(i_cfg.right_mode, i_next);
        chan[0] = ~left_dark  & (i_next.phase < i_cfg.left_red);
        chan[1] = ~left_dark  & (i_next.phase < i_cfg.left_green);
        chan[2] = ~left_dark  & (i_next.phase < i_cfg.left_blue);
        chan[3] = ~right_dark & (i_next.phase < i_cfg.right_red);
        chan[4] = ~right_dark & (i_next.phase < i_cfg.right_green);
        chan[5] = ~right_dark & (i_next.phase < i_cfg.right_blue);
    end

    assign out_take = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_chan <= chan;
            end else begin
                r_skid_chan <= chan;
            end
        end else if (out_take && r_skid_valid) begin
            r_out_chan <= r_skid_chan;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_chan  = r_out_chan;
    assign o_room      = ~r_skid_valid;

endmodule
`default_nettype wire

### hdl/dual_rgb_led_pwm_blinker.sv
// Top level of the dual RGB LED PWM blinker.
// Depends on drgb_pkg, drgb_cfg_regs, drgb_timebase and drgb_result_stage.
//
// Each word on the slave stream carries one tick in bit 0; a tick of 1 steps the
// slow and fast blink counters and the PWM phase, a tick of 0 leaves them alone.
// Every accepted word yields exactly one result word on the master stream with
// the six channel drive bits, worked out from the stepped phase, the levels and
// the blink modes of the two LEDs.
// Levels and modes are written through the plain write port; levels above 100
// are stored as 100 and mode 3 is stored as fast blink. Writes are to be made
// by the user while no word is in flight; the block does not enforce this.
// An accepted result goes to the output register, or to the one-word skid stage
// if the output is held; thus one word is taken each cycle while the skid is empty.
// When the receiver stalls, the skid word fills and s_axis_tready drops until
// the output register drains. Synchronous reset clears all levels and modes,
// zeroes the counters, puts both blink phases in their on phase and empties
// the output side.
`default_nettype none
module dual_rgb_led_pwm_blinker #(
    parameter int unsigned PWM_PERIOD      = 100,
    parameter int unsigned SLOW_HALF_TICKS = 500,
    parameter int unsigned FAST_HALF_TICKS = 100
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // bit 0: tick, bits 7..1: zero
    input  wire logic [drgb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // bits 0..5: left_red_on, left_green_on, left_blue_on,
    // right_red_on, right_green_on, right_blue_on; bits 7..6: zero
    output logic [drgb_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [drgb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [drgb_pkg::CFG_W-1:0]      i_cfg_data
);

    drgb_pkg::t_cfg               cfg;
    drgb_pkg::t_tb_state          tb_next;
    logic                         accept;
    logic                         room;
    logic [drgb_pkg::CHAN_N-1:0]  out_chan;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid & room;

    drgb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    drgb_timebase #(
        .PWM_PERIOD      (PWM_PERIOD),
        .SLOW_HALF_TICKS (SLOW_HALF_TICKS),
        .FAST_HALF_TICKS (FAST_HALF_TICKS)
    ) u_timebase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_tick   (s_axis_tdata[0]),
        .o_next   (tb_next)
    );

    drgb_result_stage u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_next      (tb_next),
        .i_cfg       (cfg),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_chan  (out_chan),
        .o_room      (room)
    );

    assign m_axis_tdata = {(drgb_pkg::M_TDATA_W-drgb_pkg::CHAN_N)'(0), out_chan};

endmodule
`default_nettype wire

### hdl/drgb_checker.sv
// Port-level checker for the dual RGB LED PWM blinker, bound to the top level.
// Depends on drgb_pkg and dual_rgb_led_pwm_blinker.
`default_nettype none
module drgb_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [drgb_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result word dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Result word changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("Output side not empty after reset.");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("Accepted word gave no result in the next cycle.");

    a_backpressure_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
        else $error("Input held off while the output side was not full.");

endmodule

bind dual_rgb_led_pwm_blinker drgb_checker u_drgb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
